// ===== sv/upd_pkg.sv =====
package upd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SLOTS           = 3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  // decoded bytes caused by one input beat, oldest in data[0]
  typedef struct packed {
    logic [SLOTS-1:0][7:0] data;
    logic [1:0]            cnt;
    logic                  fin;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// ===== sv/url_percent_decoder.sv =====
// Form-urlencoded decoder. One encoded byte is taken per cycle whenever full is
// low; plus becomes space, a percent sign with two hex digits becomes one byte,
// and a broken escape passes through literally. A byte yields zero to three
// decoded bytes, grouped and written into a QUEUE_DEPTH-entry queue (a power of
// two, at least 2); the output stage hands out one decoded byte per cycle while
// pop is high, so a byte with three results holds the queue head for three pops
// and full rises only once the queue fills. With nothing waiting ahead of it, a
// byte's group enters the queue when the byte is accepted, and its first result
// is then registered onto the result ports. run_last marks a byte's last result,
// message_end the last result of the string.
module url_percent_decoder #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_final,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       message_end
);

  logic            take;
  logic            grp_push;
  upd_pkg::group_t grp;
  upd_pkg::group_t head;
  logic            q_empty;
  logic            q_full;
  logic            q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (in_byte),
    .is_final (is_final),
    .grp_push (grp_push),
    .grp      (grp)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (grp_push),
    .wr_grp  (grp),
    .rd      (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  upd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .message_end (message_end)
  );

endmodule

// ===== sv/upd_front.sv =====
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_byte,
  input  logic             is_final,
  output logic             grp_push,
  output upd_pkg::group_t  grp
);

  upd_pkg::phase_t phase, phase_next;
  logic [7:0]      held, held_next;
  logic [1:0]      n;
  logic            do_plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PH_IDLE;
      held  <= 8'd0;
    end else if (take) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  always_comb begin
    phase_next = phase;
    held_next  = held;
    n          = 2'd0;
    do_plain   = 1'b0;
    grp.data   = '0;
    grp.fin    = is_final;

    case (phase)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::is_hex(in_byte)) begin
          held_next  = in_byte;
          phase_next = upd_pkg::PH_DIG;
        end else begin
          phase_next  = upd_pkg::PH_IDLE;
          grp.data[n] = upd_pkg::CH_PCT;
          n           = n + 2'd1;
          do_plain    = 1'b1;
        end
      end
      upd_pkg::PH_DIG: begin
        phase_next = upd_pkg::PH_IDLE;
        held_next  = 8'd0;
        if (upd_pkg::is_hex(in_byte)) begin
          grp.data[n] = {upd_pkg::hex_val(held), upd_pkg::hex_val(in_byte)};
          n           = n + 2'd1;
        end else begin
          grp.data[n] = upd_pkg::CH_PCT;
          n           = n + 2'd1;
          grp.data[n] = held;
          n           = n + 2'd1;
          do_plain    = 1'b1;
        end
      end
      default: begin
        phase_next = upd_pkg::PH_IDLE;
        do_plain   = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == upd_pkg::CH_PLUS) begin
        grp.data[n] = upd_pkg::CH_SPACE;
        n           = n + 2'd1;
      end else if (in_byte == upd_pkg::CH_PCT) begin
        phase_next = upd_pkg::PH_PCT;
      end else begin
        grp.data[n] = in_byte;
        n           = n + 2'd1;
      end
    end

    // flush anything pending on the final beat
    if (is_final) begin
      if (phase_next == upd_pkg::PH_PCT) begin
        grp.data[n] = upd_pkg::CH_PCT;
        n           = n + 2'd1;
      end else if (phase_next == upd_pkg::PH_DIG) begin
        grp.data[n] = upd_pkg::CH_PCT;
        n           = n + 2'd1;
        grp.data[n] = held_next;
        n           = n + 2'd1;
      end
      phase_next = upd_pkg::PH_IDLE;
      held_next  = 8'd0;
    end

    grp.cnt  = n;
    grp_push = take && (n != 2'd0);
  end

endmodule

// ===== sv/upd_queue.sv =====
module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  upd_pkg::group_t  wr_grp,
  input  logic             rd,
  output upd_pkg::group_t  head,
  output logic             q_empty,
  output logic             q_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  upd_pkg::group_t mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_grp;
    end
  end

  assign head    = mem[rptr];
  assign q_empty = (count == '0);
  assign q_full  = (count == (AW+1)'(DEPTH));

endmodule

// ===== sv/upd_back.sv =====
module upd_back (
  input  logic             clk,
  input  logic             rst,
  input  upd_pkg::group_t  head,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             message_end
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load  = !q_empty && (!out_valid || pop);
  assign last  = (idx == head.cnt - 2'd1);
  assign q_pop = load && last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.data[idx];
      run_last    <= last;
      message_end <= last && head.fin;
    end
  end

endmodule

// ===== sv/upd_checker.sv =====
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       is_final,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       message_end
);

  // end of string always closes the run of its last input byte
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    !empty && message_end |-> run_last)
    else $error("message_end without run_last");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(run_last) &&
                       $stable(message_end))
    else $error("waiting result beat changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("not clear after reset");

  a_accept_known: assert property (@(posedge clk) disable iff (rst)
    push && !full |-> !$isunknown({in_byte, is_final}))
    else $error("unknown input on an accepted beat");

endmodule

bind url_percent_decoder upd_checker u_chk (.*);
